// ===== rtl/sbcu_pkg.sv =====
`timescale 1ns / 1ps

package sbcu_pkg;

  localparam int TABLE_DEPTH   = 256;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int POS_W         = 16;
  localparam int ERR_POS_W     = 16;
  localparam int CP_W          = 21;
  localparam int BYTE_W        = 8;
  localparam int SURR_W        = 10;
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_UNICODE_END = 21'h110000;
  localparam logic [CP_W-1:0] CP_HIGH_FIRST  = 21'h00D800;
  localparam logic [CP_W-1:0] CP_HIGH_LAST   = 21'h00DBFF;
  localparam logic [CP_W-1:0] CP_LOW_FIRST   = 21'h00DC00;
  localparam logic [CP_W-1:0] CP_LOW_LAST    = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_SUPP_BASE   = 21'h010000;
  localparam logic [BYTE_W-1:0] C1_FIRST     = 8'h80;
  localparam logic [BYTE_W-1:0] C1_END       = 8'hA0;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_END    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CLS_PLAIN,
    CLS_LOW,
    CLS_HIGH,
    CLS_UNDEF,
    CLS_C1,
    CLS_BEYOND
  } cls_e;

  typedef enum logic [1:0] {
    ST_VALID        = 2'd0,
    ST_BADLY_FORMED = 2'd1,
    ST_INVALID      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNDEFINED = 2'd1,
    ERR_BEYOND    = 2'd2,
    ERR_SURROGATE = 2'd3
  } err_e;

  // Classified operation passed from the front end to the back end
  typedef struct packed {
    cmd_e             cmd;
    cls_e             cls;
    logic [CP_W-1:0]  entry;
  } op_t;

endpackage

// ===== rtl/sbcu_if.sv =====
`timescale 1ns / 1ps

interface sbcu_in_if import sbcu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [BYTE_W-1:0] byte_value;
  logic [CP_W-1:0]   entry_value;

  modport source (output valid, command, byte_value, entry_value, input ready);
  modport sink   (input valid, command, byte_value, entry_value, output ready);
endinterface

interface sbcu_out_if import sbcu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CP_W-1:0]      code_point;
  logic                 has_char;
  logic                 last;
  logic [1:0]           status;
  logic [1:0]           error_kind;
  logic [ERR_POS_W-1:0] error_position;

  modport source (output valid, code_point, has_char, last, status, error_kind,
                  error_position, input ready);
  modport sink   (input valid, code_point, has_char, last, status, error_kind,
                  error_position, output ready);
endinterface

// ===== rtl/sbcu_ram.sv =====
`timescale 1ns / 1ps

module sbcu_ram #(
  parameter int Width = 21,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sbcu_front.sv =====
`timescale 1ns / 1ps

module sbcu_front import sbcu_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  sbcu_in_if.sink item,
  output logic   push_valid_o,
  input  logic   push_ready_i,
  output op_t    push_data_o
);

  logic              accept;
  cmd_e              in_cmd;
  logic              s1_valid_q, s1_valid_d;
  cmd_e              s1_cmd_q;
  logic [BYTE_W-1:0] s1_byte_q;
  logic [CP_W-1:0]   rd_entry;
  cls_e              cls;

  assign in_cmd     = cmd_e'(item.command);
  assign item.ready = !s1_valid_q || push_ready_i;
  assign accept     = item.valid && item.ready;

  // Loads are finished here; everything else moves on in order
  sbcu_ram #(
    .Width (CP_W),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (accept && (in_cmd == CMD_LOAD)),
    .waddr_i (ADDR_W'(item.byte_value)),
    .wdata_i (item.entry_value),
    .re_i    (accept && (in_cmd == CMD_DECODE)),
    .raddr_i (ADDR_W'(item.byte_value)),
    .rdata_o (rd_entry)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (item.ready) begin
      s1_valid_d = accept && (in_cmd != CMD_LOAD);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q  <= in_cmd;
      s1_byte_q <= item.byte_value;
    end
  end

  // Classify the table entry in the order the decoder tests it
  always_comb begin
    if (rd_entry >= CP_LOW_FIRST && rd_entry <= CP_LOW_LAST) begin
      cls = CLS_LOW;
    end else if (rd_entry == '0) begin
      cls = CLS_UNDEF;
    end else if (rd_entry == CP_W'(s1_byte_q) && s1_byte_q >= C1_FIRST
                 && s1_byte_q < C1_END) begin
      cls = CLS_C1;
    end else if (rd_entry >= CP_UNICODE_END) begin
      cls = CLS_BEYOND;
    end else if (rd_entry >= CP_HIGH_FIRST && rd_entry <= CP_HIGH_LAST) begin
      cls = CLS_HIGH;
    end else begin
      cls = CLS_PLAIN;
    end
  end

  assign push_valid_o      = s1_valid_q;
  assign push_data_o.cmd   = s1_cmd_q;
  assign push_data_o.cls   = cls;
  assign push_data_o.entry = rd_entry;

endmodule

// ===== rtl/sbcu_fifo.sv =====
`timescale 1ns / 1ps

module sbcu_fifo import sbcu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  op_t  push_data_i,
  output logic head_valid_o,
  input  logic pop_i,
  output op_t  head_o
);

  op_t                   mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  push, pop;

  assign push_ready_o = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/sbcu_back.sv =====
`timescale 1ns / 1ps

module sbcu_back import sbcu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  op_t         head_i,
  output logic        pop_o,
  sbcu_out_if.source  result
);

  logic              held_q, held_d;
  logic [SURR_W-1:0] held_lo_q, held_lo_d;
  status_e           status_q, status_d;
  err_e              err_kind_q, err_kind_d;
  logic [POS_W-1:0]  err_pos_q, err_pos_d;
  logic [POS_W-1:0]  byte_idx_q, byte_idx_d;

  logic              out_valid_q;
  logic [CP_W-1:0]   out_cp_q;
  logic              out_has_q, out_last_q;
  status_e           out_status_q;
  err_e              out_err_kind_q;
  logic [POS_W-1:0]  out_err_pos_q;

  logic              can_emit, need_emit, fire, pop_ok, note_err, bump_idx;
  err_e              err_code;
  logic [CP_W-1:0]   res_cp;
  logic              res_has, res_last;
  logic [CP_W-1:0]   combined;

  assign can_emit = !out_valid_q || result.ready;
  assign combined = CP_SUPP_BASE + CP_W'({held_lo_q, head_i.entry[SURR_W-1:0]});

  // Step on the head op; a held surrogate in front of a character is flushed
  // first and the same op is taken again on the next step.
  always_comb begin
    held_d     = held_q;
    held_lo_d  = held_lo_q;
    status_d   = status_q;
    err_kind_d = err_kind_q;
    err_pos_d  = err_pos_q;
    byte_idx_d = byte_idx_q;
    need_emit  = 1'b0;
    pop_ok     = 1'b1;
    note_err   = 1'b0;
    err_code   = ERR_NONE;
    bump_idx   = 1'b0;
    res_cp     = CP_REPLACEMENT;
    res_has    = 1'b1;
    res_last   = 1'b1;

    unique case (head_i.cmd)
      CMD_CLEAR: begin
        held_d     = 1'b0;
        held_lo_d  = '0;
        status_d   = ST_VALID;
        err_kind_d = ERR_NONE;
        err_pos_d  = '0;
        byte_idx_d = '0;
      end
      CMD_END: begin
        need_emit = 1'b1;
        if (held_q) begin
          held_d   = 1'b0;
          note_err = 1'b1;
          err_code = ERR_SURROGATE;
        end else begin
          res_cp  = '0;
          res_has = 1'b0;
        end
      end
      CMD_DECODE: begin
        if (head_i.cls == CLS_LOW) begin
          need_emit = 1'b1;
          bump_idx  = 1'b1;
          if (held_q) begin
            held_d = 1'b0;
            res_cp = combined;
          end else begin
            note_err = 1'b1;
            err_code = ERR_SURROGATE;
          end
        end else if (held_q) begin
          need_emit = 1'b1;
          held_d    = 1'b0;
          note_err  = 1'b1;
          err_code  = ERR_SURROGATE;
          if (head_i.cls == CLS_HIGH) begin
            held_d    = 1'b1;
            held_lo_d = head_i.entry[SURR_W-1:0];
            bump_idx  = 1'b1;
          end else begin
            res_last = 1'b0;
            pop_ok   = 1'b0;
          end
        end else begin
          bump_idx = 1'b1;
          case (head_i.cls)
            CLS_HIGH: begin
              held_d    = 1'b1;
              held_lo_d = head_i.entry[SURR_W-1:0];
            end
            CLS_UNDEF: begin
              need_emit = 1'b1;
              note_err  = 1'b1;
              err_code  = ERR_UNDEFINED;
            end
            CLS_BEYOND: begin
              need_emit = 1'b1;
              note_err  = 1'b1;
              err_code  = ERR_BEYOND;
            end
            CLS_C1: begin
              need_emit = 1'b1;
              res_cp    = head_i.entry;
              if (status_q == ST_VALID) begin
                status_d = ST_BADLY_FORMED;
              end
            end
            default: begin
              need_emit = 1'b1;
              res_cp    = head_i.entry;
            end
          endcase
        end
      end
      CMD_LOAD: begin
        // loads never reach this side; drop
      end
    endcase

    if (note_err) begin
      status_d = ST_INVALID;
      if (err_kind_q == ERR_NONE) begin
        err_kind_d = err_code;
        err_pos_d  = byte_idx_q;
      end
    end

    if (head_i.cmd == CMD_END) begin
      byte_idx_d = '0;
    end else if (bump_idx && byte_idx_q != '1) begin
      byte_idx_d = byte_idx_q + 1'b1;
    end
  end

  assign fire  = head_valid_i && (!need_emit || can_emit);
  assign pop_o = fire && pop_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      held_lo_q   <= '0;
      status_q    <= ST_VALID;
      err_kind_q  <= ERR_NONE;
      err_pos_q   <= '0;
      byte_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        held_q     <= held_d;
        held_lo_q  <= held_lo_d;
        status_q   <= status_d;
        err_kind_q <= err_kind_d;
        err_pos_q  <= err_pos_d;
        byte_idx_q <= byte_idx_d;
      end
      if (can_emit) begin
        out_valid_q <= fire && need_emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && need_emit) begin
      out_cp_q       <= res_cp;
      out_has_q      <= res_has;
      out_last_q     <= res_last;
      out_status_q   <= status_d;
      out_err_kind_q <= err_kind_d;
      out_err_pos_q  <= err_pos_d;
    end
  end

  assign result.valid          = out_valid_q;
  assign result.code_point     = out_cp_q;
  assign result.has_char       = out_has_q;
  assign result.last           = out_last_q;
  assign result.status         = out_status_q;
  assign result.error_kind     = out_err_kind_q;
  assign result.error_position = ERR_POS_W'(out_err_pos_q);

endmodule

// ===== rtl/single_byte_charset_to_unicode.sv =====
`timescale 1ns / 1ps

// Single-byte charset decoder: bytes go through a 256-entry code point table.
// item_i carries commands: load a table entry, decode a byte, end of string,
// clear status. result_o carries code points with status and the first error.
// A transfer happens on a clock edge with valid and ready both high.
// Loads finish at acceptance and give no result; a decode that flushes a held
// high surrogate and then yields a character gives two results, last on the
// second. End of string always gives one result; clear gives none.
// The first result of an item goes through the table read register (loaded at
// the transfer edge), then the queue and the result register. One item per
// cycle is accepted while result_o takes results, set by the single table
// read port and the one-result-per-cycle output register.
// A two-result decode holds the queue head while the flushed surrogate is emitted.
// Reset clears status, error record, byte index and held surrogate; the table
// is not cleared and must be loaded before bytes that use it are decoded.
// When result_o stalls, the result register, a two-entry queue and the
// table read stage fill, then item_i.ready drops until the receiver takes data.
module single_byte_charset_to_unicode import sbcu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbcu_in_if.sink     item_i,
  sbcu_out_if.source  result_o
);

  logic push_valid, push_ready, head_valid, pop;
  op_t  push_data, head;

  sbcu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item         (item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  sbcu_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_o       (head)
  );

  sbcu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .result       (result_o)
  );

`ifndef NO_ASSERTIONS
  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && !push_ready) |=> (push_valid && $stable(push_data)))
    else $error("stalled front-end op changed");

  a_end_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.has_char) |->
      (result_o.last && result_o.code_point == '0))
    else $error("bare end marker malformed");

  a_error_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.error_kind != ERR_NONE) |->
      (result_o.status == ST_INVALID))
    else $error("recorded error without invalid status");
`endif

endmodule

// ===== test/charset_decode_checker.sv =====
`timescale 1ns / 1ps

module charset_decode_checker import sbcu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sbcu_in_if   item_i,
  sbcu_out_if  result_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [CP_W-1:0]      code_point;
    logic                 has_char;
    logic                 last;
    status_e              status;
    err_e                 error_kind;
    logic [ERR_POS_W-1:0] error_position;
  } char_result_t;

  // Local copy of the decoder state
  logic [CP_W-1:0]      code_table [TABLE_DEPTH];
  logic [CP_W-1:0]      held_high;
  logic                 held;
  status_e              run_status;
  err_e                 first_kind;
  logic [ERR_POS_W-1:0] first_pos;
  logic [POS_W-1:0]     byte_idx;

  char_result_t step_chars [$];
  char_result_t expected_chars [$];

  task automatic clear_run();
    held_high  = '0;
    held       = 1'b0;
    run_status = ST_VALID;
    first_kind = ERR_NONE;
    first_pos  = '0;
    byte_idx   = '0;
  endtask

  task automatic record_error(err_e kind);
    run_status = ST_INVALID;
    if (first_kind == ERR_NONE) begin
      first_kind = kind;
      first_pos  = byte_idx;
    end
  endtask

  task automatic push_char(logic [CP_W-1:0] cp, logic has);
    char_result_t r;
    r.code_point     = cp;
    r.has_char       = has;
    r.last           = 1'b0;
    r.status         = run_status;
    r.error_kind     = first_kind;
    r.error_position = first_pos;
    step_chars.push_back(r);
  endtask

  task automatic flush_high();
    if (held) begin
      held      = 1'b0;
      held_high = '0;
      record_error(ERR_SURROGATE);
      push_char(CP_REPLACEMENT, 1'b1);
    end
  endtask

  task automatic decode_char(logic [BYTE_W-1:0] b);
    logic [CP_W-1:0] entry;
    logic [CP_W-1:0] cp;
    entry = code_table[b];
    if (entry >= CP_LOW_FIRST && entry <= CP_LOW_LAST) begin
      if (held) begin
        cp = ((held_high - CP_HIGH_FIRST) << SURR_W) + (entry - CP_LOW_FIRST) + CP_SUPP_BASE;
        held      = 1'b0;
        held_high = '0;
        push_char(cp, 1'b1);
      end else begin
        record_error(ERR_SURROGATE);
        push_char(CP_REPLACEMENT, 1'b1);
      end
    end else begin
      flush_high();
      if (entry == '0) begin
        record_error(ERR_UNDEFINED);
        push_char(CP_REPLACEMENT, 1'b1);
      end else if (entry == CP_W'(b) && b >= C1_FIRST && b < C1_END) begin
        if (run_status == ST_VALID) run_status = ST_BADLY_FORMED;
        push_char(entry, 1'b1);
      end else if (entry >= CP_UNICODE_END) begin
        record_error(ERR_BEYOND);
        push_char(CP_REPLACEMENT, 1'b1);
      end else if (entry >= CP_HIGH_FIRST && entry <= CP_HIGH_LAST) begin
        held_high = entry;
        held      = 1'b1;
      end else begin
        push_char(entry, 1'b1);
      end
    end
  endtask

  task automatic predict_chars(cmd_e cmd, logic [BYTE_W-1:0] b, logic [CP_W-1:0] v);
    step_chars.delete();
    case (cmd)
      CMD_LOAD: code_table[b] = v;
      CMD_DECODE: begin
        decode_char(b);
        if (byte_idx != '1) byte_idx++;
      end
      CMD_END: begin
        if (held) flush_high();
        else push_char('0, 1'b0);
        byte_idx = '0;
      end
      default: clear_run();
    endcase
    if (step_chars.size() > 0) step_chars[step_chars.size()-1].last = 1'b1;
    foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o++;
    end
  endfunction

  task automatic compare_char();
    char_result_t want;
    if (expected_chars.size() == 0) begin
      $error("unexpected result: code_point 0x%0h", result_i.code_point);
      fail_count_o++;
    end else begin
      want = expected_chars.pop_front();
      check_field("code_point", want.code_point, result_i.code_point);
      check_field("has_char", want.has_char, result_i.has_char);
      check_field("last", want.last, result_i.last);
      check_field("status", want.status, result_i.status);
      check_field("error_kind", want.error_kind, result_i.error_kind);
      check_field("error_position", want.error_position, result_i.error_position);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_run();
      expected_chars.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (result_i.valid && result_i.ready) compare_char();
      if (item_i.valid && item_i.ready)
        predict_chars(cmd_e'(item_i.command), item_i.byte_value, item_i.entry_value);
      pending_o = expected_chars.size();
    end
  end

endmodule

// ===== test/single_byte_charset_to_unicode_tb.sv =====
`timescale 1ns / 1ps

module single_byte_charset_to_unicode_tb;
  import sbcu_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 400;
  localparam int TAIL_RUN      = 4;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   sent_cnt;
  int   idle_cycles;
  bit   tx_idle;
  bit   rx_idle;
  bit   churn;
  bit   hold_req;

  // Table contents as loaded, used to steer byte choice
  logic [CP_W-1:0] shadow_table [TABLE_DEPTH];

  sbcu_in_if  item_if ();
  sbcu_out_if result_if ();

  single_byte_charset_to_unicode DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_if),
    .result_o(result_if)
  );

  charset_decode_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .item_i      (item_if),
    .result_i    (result_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Result side: random short stalls, one long hold on request
  initial begin
    int stall_left;
    stall_left      = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) stall_left--;
      else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end else if (rx_idle && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
      result_if.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send(cmd_e cmd, logic [BYTE_W-1:0] b, logic [CP_W-1:0] v);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    item_if.valid       <= 1'b1;
    item_if.command     <= cmd;
    item_if.byte_value  <= b;
    item_if.entry_value <= v;
    do @(posedge clk); while (!item_if.ready);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic load(logic [BYTE_W-1:0] b, logic [CP_W-1:0] v);
    shadow_table[b] = v;
    send(CMD_LOAD, b, v);
  endtask

  task automatic decode(logic [BYTE_W-1:0] b);
    send(CMD_DECODE, b, CP_W'($urandom_range(0, 21'h1FFFFF)));
  endtask

  task automatic noise_cmd(cmd_e cmd);
    send(cmd, BYTE_W'($urandom_range(0, 255)), CP_W'($urandom_range(0, 21'h1FFFFF)));
  endtask

  function automatic logic [CP_W-1:0] rand_entry(logic [BYTE_W-1:0] b);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CP_W'(b);
      2, 3:    return CP_HIGH_FIRST + CP_W'($urandom_range(0, 1023));
      4, 5:    return CP_LOW_FIRST + CP_W'($urandom_range(0, 1023));
      6:       return CP_W'($urandom_range(CP_UNICODE_END, 21'h1FFFFF));
      7:       return CP_W'($urandom_range(0, 21'h1FFFFF));
      default: return CP_W'($urandom_range(1, 21'h10FFFF));
    endcase
  endfunction

  // Look for a byte whose entry falls in a range; fall back to any byte
  function automatic logic [BYTE_W-1:0] pick_byte(logic [CP_W-1:0] lo, logic [CP_W-1:0] hi);
    logic [BYTE_W-1:0] b;
    b = '0;
    for (int n = 0; n < 64; n++) begin
      b = BYTE_W'($urandom_range(0, 255));
      if (shadow_table[b] >= lo && shadow_table[b] <= hi) return b;
    end
    return b;
  endfunction

  task automatic random_items(int count);
    int stop;
    int r;
    logic [BYTE_W-1:0] b;
    stop = sent_cnt + count;
    while (sent_cnt < stop) begin
      if (churn && $urandom_range(0, 63) == 0) begin
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        b = BYTE_W'($urandom_range(0, 255));
        load(b, rand_entry(b));
      end else if (r < 13) noise_cmd(CMD_END);
      else if (r < 15) noise_cmd(CMD_CLEAR);
      else if (r < 45) begin
        // mostly well-formed surrogate pairs, some broken
        decode(pick_byte(CP_HIGH_FIRST, CP_HIGH_LAST));
        if ($urandom_range(0, 4) != 0) decode(pick_byte(CP_LOW_FIRST, CP_LOW_LAST));
      end else decode(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    item_if.valid       = 1'b0;
    item_if.command     = CMD_LOAD;
    item_if.byte_value  = '0;
    item_if.entry_value = '0;
    sent_cnt    = 0;
    tx_idle     = 1'b0;
    rx_idle     = 1'b0;
    churn       = 1'b0;
    hold_req    = 1'b0;
    rst_n       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    load(8'h41, 21'h000041);
    load(8'h00, 21'h000000);
    load(8'h85, 21'h000085);
    load(8'hFF, 21'h1FFFFF);
    load(8'hD0, CP_HIGH_FIRST);
    load(8'hDF, CP_LOW_LAST);
    load(8'h9F, 21'h10FFFF);
    decode(8'h41);
    decode(8'h85);
    decode(8'hD0);
    decode(8'hDF);
    decode(8'hDF);
    noise_cmd(CMD_CLEAR);
    decode(8'hD0);
    decode(8'h41);
    decode(8'hD0);
    noise_cmd(CMD_END);
    noise_cmd(CMD_END);
    decode(8'h00);
    decode(8'hFF);
    decode(8'h9F);
    decode(8'hD0);
    decode(8'hD0);
    noise_cmd(CMD_END);
    noise_cmd(CMD_CLEAR);

    for (int i = 0; i < TABLE_DEPTH; i++) load(i[BYTE_W-1:0], rand_entry(i[BYTE_W-1:0]));

    churn   = 1'b1;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    random_items(RANDOM_ITEMS / 3);
    // hold the result side while items keep coming, so the input stalls
    hold_req = 1'b1;
    random_items(RANDOM_ITEMS / 3);
    drain();
    random_items(RANDOM_ITEMS / 3);

    churn   = 1'b0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    // record an error after a short run of plain bytes
    load(8'h41, 21'h000041);
    load(8'h00, 21'h000000);
    noise_cmd(CMD_CLEAR);
    for (int i = 0; i < TAIL_RUN; i++) decode(8'h41);
    decode(8'h00);
    noise_cmd(CMD_END);
    noise_cmd(CMD_CLEAR);
    random_items(60);

    drain();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
